// ===== rtl/pixel_format_pack_unpack_unit_assert.svh =====
// Assertion macros for the pixel format pack/unpack unit.
// Included by modules that check their own control logic; no other dependencies.
`ifndef PIXEL_FORMAT_PACK_UNPACK_UNIT_ASSERT_SVH
`define PIXEL_FORMAT_PACK_UNPACK_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define PFPU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define PFPU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfpu_pkg.sv =====
// Shared types, codes, reset values and channel helper functions for the
// pixel format pack/unpack unit. No dependencies.
package pfpu_pkg;

    // Palette depth default
    localparam int PALETTE_SIZE_DEF = 256;

    // Channel slots
    localparam int CHAN_NUM   = 4;
    localparam int CHAN_RED   = 0;
    localparam int CHAN_GREEN = 1;
    localparam int CHAN_BLUE  = 2;
    localparam int CHAN_ALPHA = 3;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Beat geometry
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;

    // Register reset values
    localparam logic [2:0]  BPP_RST         = 3'd4;
    localparam logic [2:0]  BPP_PALETTED    = 3'd1;
    localparam logic [31:0] RED_MASK_RST    = 32'h0000_00FF;
    localparam logic [31:0] GREEN_MASK_RST  = 32'h0000_FF00;
    localparam logic [31:0] BLUE_MASK_RST   = 32'h00FF_0000;
    localparam logic [31:0] ALPHA_MASK_RST  = 32'hFF00_0000;

    // Cycles the input stays closed while channel formats recompute
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    typedef enum logic [2:0] {
        REG_BPP        = 3'd0,
        REG_RED_MASK   = 3'd1,
        REG_GREEN_MASK = 3'd2,
        REG_BLUE_MASK  = 3'd3,
        REG_ALPHA_MASK = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_PACK   = 2'd1,
        KIND_UNPACK = 2'd2
    } item_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_LOOKUP = 2'd1,
        ST_SEARCH = 2'd2
    } pfpu_state_t;

    // Decoded channel format: position of the field and bits dropped from 8
    typedef struct packed {
        logic [4:0] shift;
        logic [3:0] loss;
    } chan_fmt_t;

    // Count trailing zeros; an empty mask gives 0
    function automatic logic [4:0] ctz32(input logic [31:0] m);
        logic [4:0] s;
        s = '0;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) begin
                s = 5'(i);
            end
        end
        return s;
    endfunction

    // Loss from the low byte of the mask shifted down to its lowest set bit
    function automatic logic [3:0] loss_of(input logic [7:0] low);
        logic [3:0] n;
        logic       run;
        n   = '0;
        run = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (run && low[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return 4'd8 - n;
    endfunction

    function automatic logic [31:0] pack_chan(input logic [7:0] v, input chan_fmt_t f);
        logic [31:0] w;
        w = 32'(v >> f.loss);
        return w << f.shift;
    endfunction

    function automatic logic [7:0] unpack_chan(input logic [31:0] px,
                                               input logic [31:0] m,
                                               input chan_fmt_t   f);
        logic [31:0] t;
        t = (px & m) >> f.shift;
        return t[7:0] << f.loss;
    endfunction

endpackage

// ===== rtl/pfpu_chan_decode.sv =====
// Two-stage decoder from a channel mask to its shift and loss.
// Depends on pfpu_pkg.
module pfpu_chan_decode (
    input  logic                aclk,
    input  logic [31:0]         mask,
    output pfpu_pkg::chan_fmt_t fmt
);
    import pfpu_pkg::*;

    logic [4:0] shift_reg;
    logic [3:0] loss_reg;
    logic [7:0] mask_sh;

    // Stage one: find the lowest set bit
    always_ff @(posedge aclk) begin
        shift_reg <= ctz32(mask);
    end

    // Stage two: measure the run of ones above it
    assign mask_sh = 8'(mask >> shift_reg);

    always_ff @(posedge aclk) begin
        loss_reg <= loss_of(mask_sh);
    end

    assign fmt.shift = shift_reg;
    assign fmt.loss  = loss_reg;

endmodule

// ===== rtl/pixel_format_pack_unpack_unit.sv =====
// Direct pack/unpack: one beat per cycle while the result side accepts; result out in the
// cycle after the beat. Paletted unpack passes the palette read register and lookup state;
// paletted pack scans one palette entry per cycle off the read port. A configuration write
// closes the input while formats re-decode; reset (synchronous, active low) does the same.
// Palette entries read as zero until loaded (per-entry valid flops), no clearing pass.
// Depends on pfpu_pkg, pfpu_chan_decode and pixel_format_pack_unpack_unit_assert.svh.
`include "pixel_format_pack_unpack_unit_assert.svh"

module pixel_format_pack_unpack_unit #(
    parameter int PALETTE_SIZE = pfpu_pkg::PALETTE_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pfpu_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pfpu_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pfpu_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // pixel_value[31:0], red[39:32], green[47:40], blue[55:48], alpha[63:56],
    // entry_index[71:64]
    input  logic [pfpu_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [pfpu_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // Result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // packed_pixel[31:0], red_out[39:32], green_out[47:40], blue_out[55:48]
    output logic [pfpu_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // found[0]
    output logic                             m_axis_tuser
);
    import pfpu_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_SIZE);

    // Configuration registers
    logic [2:0]  bpp_reg;
    logic [31:0] mask_reg [CHAN_NUM];
    logic [1:0]  settle_cnt_reg;
    logic        cfg_wr;
    cfg_reg_t    cfg_sel;

    // Decoded channel formats
    chan_fmt_t   fmt [CHAN_NUM];

    // Input beat fields
    item_kind_t  in_kind;
    logic [31:0] in_px;
    logic [7:0]  in_r, in_g, in_b, in_a, in_idx;
    logic [31:0] in_rgba;
    logic        in_accept;
    logic        paletted;

    // Palette memory and valid bits
    logic [31:0]      mem [PALETTE_SIZE];
    logic             valid_reg [PALETTE_SIZE];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [31:0]      rd_data_reg;
    logic             rd_valid_reg;
    logic [31:0]      entry;

    // Sequencer
    pfpu_state_t      state_reg, state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [31:0]      target_reg, target_next;
    logic             oor_reg, oor_next;
    logic             hit;

    // Output register
    logic        m_valid_reg;
    logic [31:0] m_pixel_reg, out_pixel;
    logic [7:0]  m_r_reg, m_g_reg, m_b_reg, out_r, out_g, out_b;
    logic        m_found_reg, out_found;
    logic        out_load;
    logic        out_free;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg              <= BPP_RST;
            mask_reg[CHAN_RED]   <= RED_MASK_RST;
            mask_reg[CHAN_GREEN] <= GREEN_MASK_RST;
            mask_reg[CHAN_BLUE]  <= BLUE_MASK_RST;
            mask_reg[CHAN_ALPHA] <= ALPHA_MASK_RST;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_BPP:        bpp_reg              <= pwdata[2:0];
                REG_RED_MASK:   mask_reg[CHAN_RED]   <= pwdata;
                REG_GREEN_MASK: mask_reg[CHAN_GREEN] <= pwdata;
                REG_BLUE_MASK:  mask_reg[CHAN_BLUE]  <= pwdata;
                REG_ALPHA_MASK: mask_reg[CHAN_ALPHA] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_BPP:        prdata = {29'd0, bpp_reg};
            REG_RED_MASK:   prdata = mask_reg[CHAN_RED];
            REG_GREEN_MASK: prdata = mask_reg[CHAN_GREEN];
            REG_BLUE_MASK:  prdata = mask_reg[CHAN_BLUE];
            REG_ALPHA_MASK: prdata = mask_reg[CHAN_ALPHA];
            default:        prdata = '0;
        endcase
    end

    // Hold the input closed until decoded formats catch up with the masks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_cnt_reg <= SETTLE_CYCLES;
        end else if (cfg_wr) begin
            settle_cnt_reg <= SETTLE_CYCLES;
        end else if (settle_cnt_reg != 2'd0) begin
            settle_cnt_reg <= settle_cnt_reg - 2'd1;
        end
    end

    // ---------------- channel decoders ----------------
    for (genvar c = 0; c < CHAN_NUM; c++) begin : g_dec
        pfpu_chan_decode u_dec (
            .aclk (aclk),
            .mask (mask_reg[c]),
            .fmt  (fmt[c])
        );
    end

    // ---------------- input beat ----------------
    assign in_kind  = item_kind_t'(s_axis_tuser);
    assign in_px    = s_axis_tdata[31:0];
    assign in_r     = s_axis_tdata[39:32];
    assign in_g     = s_axis_tdata[47:40];
    assign in_b     = s_axis_tdata[55:48];
    assign in_a     = s_axis_tdata[63:56];
    assign in_idx   = s_axis_tdata[71:64];
    assign in_rgba  = {in_a, in_b, in_g, in_r};
    assign paletted = (bpp_reg == BPP_PALETTED);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (settle_cnt_reg == 2'd0) && out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // ---------------- palette memory ----------------
    // Writes only happen from the idle state, so a write never overlaps a lookup or search
    assign mem_we    = in_accept && (in_kind == KIND_LOAD) && ({1'b0, in_idx} < 9'(PALETTE_SIZE));
    assign mem_waddr = IDX_W'(in_idx);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= in_rgba;
        end
        rd_data_reg  <= mem[mem_raddr];
        rd_valid_reg <= valid_reg[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PALETTE_SIZE; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (mem_we) begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    // Unloaded entries read as zero
    assign entry = rd_valid_reg ? rd_data_reg : 32'd0;
    assign hit   = (entry == target_reg);

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        target_reg   <= target_next;
        oor_reg      <= oor_next;
    end

    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        target_next   = target_reg;
        oor_next      = oor_reg;
        mem_raddr     = '0;
        out_load      = 1'b0;
        out_pixel     = '0;
        out_found     = 1'b0;
        out_r         = '0;
        out_g         = '0;
        out_b         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_kind == KIND_UNPACK) begin
                    mem_raddr = IDX_W'(in_px);
                end
                if (in_accept) begin
                    case (in_kind)
                        KIND_PACK: begin
                            if (paletted) begin
                                // Start the scan at entry zero
                                scan_idx_next = '0;
                                target_next   = in_rgba;
                                state_next    = ST_SEARCH;
                            end else begin
                                out_load  = 1'b1;
                                out_found = 1'b1;
                                out_pixel = pack_chan(in_r, fmt[CHAN_RED])
                                          | pack_chan(in_g, fmt[CHAN_GREEN])
                                          | pack_chan(in_b, fmt[CHAN_BLUE])
                                          | pack_chan(in_a, fmt[CHAN_ALPHA]);
                            end
                        end
                        KIND_UNPACK: begin
                            if (paletted) begin
                                oor_next   = (in_px >= 32'(PALETTE_SIZE));
                                state_next = ST_LOOKUP;
                            end else begin
                                out_load = 1'b1;
                                out_r = unpack_chan(in_px, mask_reg[CHAN_RED],   fmt[CHAN_RED]);
                                out_g = unpack_chan(in_px, mask_reg[CHAN_GREEN], fmt[CHAN_GREEN]);
                                out_b = unpack_chan(in_px, mask_reg[CHAN_BLUE],  fmt[CHAN_BLUE]);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                // Output register is empty here: it was free when the beat came in
                out_load = 1'b1;
                if (!oor_reg) begin
                    out_r = entry[7:0];
                    out_g = entry[15:8];
                    out_b = entry[23:16];
                end
                state_next = ST_IDLE;
            end
            ST_SEARCH: begin
                mem_raddr = scan_idx_reg + IDX_W'(1);
                if (hit) begin
                    out_load   = 1'b1;
                    out_found  = 1'b1;
                    out_pixel  = 32'(scan_idx_reg);
                    state_next = ST_IDLE;
                end else if (scan_idx_reg == IDX_W'(PALETTE_SIZE - 1)) begin
                    // Miss: report with zero pixel and found low
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pixel_reg <= out_pixel;
            m_found_reg <= out_found;
            m_r_reg     <= out_r;
            m_g_reg     <= out_g;
            m_b_reg     <= out_b;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_b_reg, m_g_reg, m_r_reg, m_pixel_reg};
    assign m_axis_tuser  = m_found_reg;

    // ---------------- assertions ----------------
    `PFPU_ASSERT_NOW(a_busy_out_empty, aclk, aresetn,
        (state_reg != ST_IDLE), !m_axis_tvalid, "result pending while palette access busy")
    `PFPU_ASSERT_NEXT(a_pal_pack_scans, aclk, aresetn,
        in_accept && (in_kind == KIND_PACK) && paletted, state_reg == ST_SEARCH,
        "paletted pack did not start a scan")
    `PFPU_ASSERT_NOW(a_settle_closed, aclk, aresetn,
        (settle_cnt_reg != 2'd0), !s_axis_tready, "input open while formats settle")
    `PFPU_ASSERT_NOW(a_miss_zero, aclk, aresetn,
        m_axis_tvalid && !m_axis_tuser, m_axis_tdata[31:0] == 32'd0,
        "result without found carries a nonzero pixel")
    `PFPU_ASSERT_NEXT(a_load_no_result, aclk, aresetn,
        in_accept && (in_kind != KIND_PACK) && (in_kind != KIND_UNPACK), !m_axis_tvalid,
        "load or unused beat produced a result")

endmodule

// ===== dv/tb_pixel_format_pack_unpack_unit.sv =====
// Self-checking testbench for pixel_format_pack_unpack_unit: drives pack, unpack, load and
// unused beats, mostly under random idling; checks every result beat against a predictor.
// Depends on pfpu_pkg and the pixel_format_pack_unpack_unit RTL.
module tb_pixel_format_pack_unpack_unit;
    import pfpu_pkg::*;

    localparam int          PAL_DEPTH    = PALETTE_SIZE_DEF;
    localparam int          QUIET_CYCLES = PAL_DEPTH + 44;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          MAX_REPORTS  = 10;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] pixel_value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  entry_index;
    } pixel_item_t;

    typedef struct {
        logic [31:0] packed_pixel;
        logic        found;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
    } pixel_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tuser;

    // Predictor state: configuration and palette as the block should hold them
    logic [2:0]             cur_bpp = BPP_RST;
    logic [31:0]            chan_masks [CHAN_NUM] = '{RED_MASK_RST, GREEN_MASK_RST,
                                                      BLUE_MASK_RST, ALPHA_MASK_RST};
    logic [31:0]            shadow_palette [PAL_DEPTH];
    pixel_result_t          expected_conversions [$];

    bit                     sender_gaps = 1'b1;
    bit                     receiver_stalls = 1'b1;
    int                     hold_left = 0;
    int                     hold_requests = 0;
    int                     hold_seen = 0;
    int                     error_count = 0;
    int                     cycle_count = 0;

    pixel_format_pack_unpack_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Channel position: trailing zeros of the mask, 0 when empty
    function automatic int unsigned chan_shift(logic [31:0] m);
        int unsigned s;
        s = 0;
        if (m == '0) return 0;
        while (!m[s]) s++;
        return s;
    endfunction

    // Bits dropped from 8: only the lowest run of ones counts
    function automatic int unsigned chan_loss(logic [31:0] m);
        int unsigned pos;
        int unsigned run;
        if (m == '0) return 8;
        pos = chan_shift(m);
        run = 0;
        while (pos + run < 32 && m[pos + run]) run++;
        return (run >= 8) ? 0 : 8 - run;
    endfunction

    function automatic logic [31:0] pack_channel(logic [7:0] v, logic [31:0] m);
        logic [31:0] w;
        w = {24'd0, v} >> chan_loss(m);
        return w << chan_shift(m);
    endfunction

    function automatic logic [7:0] unpack_channel(logic [31:0] px, logic [31:0] m);
        logic [31:0] t;
        t = ((px & m) >> chan_shift(m)) << chan_loss(m);
        return t[7:0];
    endfunction

    function automatic pixel_item_t mk_item(logic [1:0] kind, logic [31:0] px,
                                            logic [31:0] rgba, logic [7:0] idx);
        pixel_item_t it;
        it.kind        = kind;
        it.pixel_value = px;
        it.red         = rgba[7:0];
        it.green       = rgba[15:8];
        it.blue        = rgba[23:16];
        it.alpha       = rgba[31:24];
        it.entry_index = idx;
        return it;
    endfunction

    // Contiguous masks mostly, with empty and arbitrary ones mixed in
    function automatic logic [31:0] random_mask();
        int unsigned width;
        int unsigned pos;
        logic [63:0] ones;
        logic [31:0] m;
        case ($urandom_range(0, 9))
            0: m = $urandom();
            1: m = '0;
            default: begin
                width = $urandom_range(1, 12);
                pos   = $urandom_range(0, 31);
                ones  = (64'd1 << width) - 64'd1;
                m     = 32'(ones << pos);
            end
        endcase
        return m;
    endfunction

    // Apply one accepted beat to the predictor and queue its result, if any
    task automatic convert_pixel(pixel_item_t it);
        pixel_result_t res;
        logic [31:0]   rgba;
        logic [31:0]   entry;
        rgba = {it.alpha, it.blue, it.green, it.red};
        res  = '{packed_pixel: '0, found: 1'b0, red_out: '0, green_out: '0, blue_out: '0};
        case (it.kind)
            KIND_LOAD: begin
                shadow_palette[it.entry_index] = rgba;
            end
            KIND_PACK: begin
                if (cur_bpp == BPP_PALETTED) begin
                    for (int i = 0; i < PAL_DEPTH; i++) begin
                        if (!res.found && shadow_palette[i] == rgba) begin
                            res.packed_pixel = 32'(i);
                            res.found        = 1'b1;
                        end
                    end
                end else begin
                    res.packed_pixel = pack_channel(it.red,   chan_masks[CHAN_RED])
                                     | pack_channel(it.green, chan_masks[CHAN_GREEN])
                                     | pack_channel(it.blue,  chan_masks[CHAN_BLUE])
                                     | pack_channel(it.alpha, chan_masks[CHAN_ALPHA]);
                    res.found = 1'b1;
                end
                expected_conversions.push_back(res);
            end
            KIND_UNPACK: begin
                if (cur_bpp == BPP_PALETTED) begin
                    // Index beyond the palette reads as all zero
                    if (it.pixel_value < PAL_DEPTH) begin
                        entry         = shadow_palette[it.pixel_value[7:0]];
                        res.red_out   = entry[7:0];
                        res.green_out = entry[15:8];
                        res.blue_out  = entry[23:16];
                    end
                end else begin
                    res.red_out   = unpack_channel(it.pixel_value, chan_masks[CHAN_RED]);
                    res.green_out = unpack_channel(it.pixel_value, chan_masks[CHAN_GREEN]);
                    res.blue_out  = unpack_channel(it.pixel_value, chan_masks[CHAN_BLUE]);
                end
                expected_conversions.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    // Offer one beat and hold it until accepted
    task automatic send_beat(pixel_item_t it);
        while (sender_gaps && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.entry_index, it.alpha, it.blue, it.green, it.red, it.pixel_value};
        s_axis_tuser  <= it.kind;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        convert_pixel(it);
    endtask

    // Stop offering, wait for all results, then let trailing loads settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_conversions.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup phase, access phase, then back to idle
    task automatic set_register(cfg_reg_t r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (r)
            REG_BPP:        cur_bpp = v[2:0];
            REG_RED_MASK:   chan_masks[CHAN_RED] = v;
            REG_GREEN_MASK: chan_masks[CHAN_GREEN] = v;
            REG_BLUE_MASK:  chan_masks[CHAN_BLUE] = v;
            REG_ALPHA_MASK: chan_masks[CHAN_ALPHA] = v;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_format(logic [2:0] bpp, logic [31:0] rm, logic [31:0] gm,
                              logic [31:0] bm, logic [31:0] am);
        set_register(REG_BPP, {29'd0, bpp});
        set_register(REG_RED_MASK, rm);
        set_register(REG_GREEN_MASK, gm);
        set_register(REG_BLUE_MASK, bm);
        set_register(REG_ALPHA_MASK, am);
    endtask

    function automatic pixel_item_t random_direct_item();
        pixel_item_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        it   = mk_item(KIND_PACK, $urandom(), $urandom(), 8'($urandom_range(0, 255)));
        if (pick < 7) it.kind = KIND_LOAD;
        else if (pick < 10) it.kind = KIND_UNUSED;
        else if (pick < 55) it.kind = KIND_UNPACK;
        return it;
    endfunction

    // Receiver: honor a requested hold-off, otherwise stall at random unless stalls are off
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !receiver_stalls || ($urandom_range(0, 99) >= 36);
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        pixel_result_t want;
        pixel_result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.packed_pixel = m_axis_tdata[31:0];
            got.red_out      = m_axis_tdata[39:32];
            got.green_out    = m_axis_tdata[47:40];
            got.blue_out     = m_axis_tdata[55:48];
            got.found        = m_axis_tuser;
            if (expected_conversions.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("ERROR: result beat with none expected: pixel %h found %b",
                             got.packed_pixel, got.found);
            end else begin
                want = expected_conversions.pop_front();
                if (got.packed_pixel !== want.packed_pixel || got.found !== want.found ||
                    got.red_out !== want.red_out || got.green_out !== want.green_out ||
                    got.blue_out !== want.blue_out) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: expected pixel %h found %b rgb %h %h %h, got %h %b %h %h %h",
                                 want.packed_pixel, want.found, want.red_out, want.green_out,
                                 want.blue_out, got.packed_pixel, got.found, got.red_out,
                                 got.green_out, got.blue_out);
                end
            end
        end
    end

    // Reset format: channel extremes, packs and unpacks, a load and an unused kind
    task automatic test_direct_defaults();
        send_beat(mk_item(KIND_PACK, 32'h0, 32'h0000_0000, 8'd0));
        send_beat(mk_item(KIND_PACK, 32'h0, 32'hFFFF_FFFF, 8'd0));
        send_beat(mk_item(KIND_PACK, 32'h0, 32'h7856_3412, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'hFFFF_FFFF, 32'h0, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'h0000_0000, 32'h0, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'h8765_4321, 32'h0, 8'd0));
        // A load in direct mode still writes the palette
        send_beat(mk_item(KIND_LOAD, 32'h0, 32'hA1B2_C3D4, 8'd128));
        send_beat(mk_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
        drain_results();
    endtask

    // Wide, non-contiguous, empty and top-bit masks
    task automatic test_mask_corners();
        set_format(3'd2, 32'h0000_FFFF, 32'h00F3_0000, 32'h0000_0000, 32'h8000_0000);
        send_beat(mk_item(KIND_PACK, 32'h0, 32'hFFFF_FFFF, 8'd0));
        send_beat(mk_item(KIND_PACK, 32'h0, 32'h7FC0_4080, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'hFFFF_FFFF, 32'h0, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'h00A5_A5A5, 32'h0, 8'd0));
        drain_results();
    endtask

    // Paletted mode: first match, miss, full-depth search, index out of range
    task automatic test_palette_directed();
        set_register(REG_BPP, {29'd0, BPP_PALETTED});
        send_beat(mk_item(KIND_PACK, 32'h0, 32'h0000_0000, 8'd0));
        send_beat(mk_item(KIND_PACK, 32'h0, 32'hA1B2_C3D4, 8'd0));
        send_beat(mk_item(KIND_LOAD, 32'h0, 32'h1122_3344, 8'd255));
        send_beat(mk_item(KIND_PACK, 32'h0, 32'h1122_3344, 8'd0));
        send_beat(mk_item(KIND_PACK, 32'h0, 32'hDEAD_BEEF, 8'd0));
        send_beat(mk_item(KIND_LOAD, 32'h0, 32'h1122_3344, 8'd7));
        send_beat(mk_item(KIND_PACK, 32'h0, 32'h1122_3344, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'd255, 32'h0, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'd256, 32'h0, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'hFFFF_FFFF, 32'h0, 8'd0));
        send_beat(mk_item(KIND_UNPACK, 32'd128, 32'h0, 8'd0));
        send_beat(mk_item(KIND_UNUSED, 32'd7, 32'h1122_3344, 8'd7));
        drain_results();
    endtask

    // Several direct formats, the all-ones and all-zero masks among them
    task automatic test_random_direct();
        logic [2:0] bpp;
        for (int s = 0; s < 5; s++) begin
            bpp = 3'($urandom_range(2, 4));
            if (s == 0) set_format(3'd4, '1, '1, '1, '1);
            else if (s == 1) set_format(3'd3, '0, '0, '0, '0);
            else set_format(bpp, random_mask(), random_mask(), random_mask(), random_mask());
            repeat (80) send_beat(random_direct_item());
            drain_results();
        end
    endtask

    // Load colors first, then mix more loads, lookups of known colors, misses and unpacks
    task automatic test_random_palette();
        logic [31:0] loaded_colors [$];
        logic [31:0] rgba;
        int unsigned pick;
        set_register(REG_BPP, {29'd0, BPP_PALETTED});
        for (int n = 0; n < 200; n++) begin
            pick = (n < 24) ? 0 : $urandom_range(0, 99);
            rgba = $urandom();
            if (pick < 15) begin
                loaded_colors.push_back(rgba);
                send_beat(mk_item(KIND_LOAD, $urandom(), rgba, 8'($urandom_range(0, 255))));
            end else if (pick < 55) begin
                rgba = loaded_colors[$urandom_range(0, loaded_colors.size() - 1)];
                send_beat(mk_item(KIND_PACK, $urandom(), rgba, 8'($urandom_range(0, 255))));
            end else if (pick < 70) begin
                send_beat(mk_item(KIND_PACK, $urandom(), rgba, 8'($urandom_range(0, 255))));
            end else if (pick < 95) begin
                send_beat(mk_item(KIND_UNPACK, $urandom_range(0, 255), rgba, 8'd0));
            end else begin
                send_beat(mk_item(KIND_UNPACK, $urandom(), rgba, 8'd0));
            end
        end
        drain_results();
    endtask

    // Back-to-back beats on both sides with no idling at all
    task automatic test_full_rate();
        set_format(BPP_RST, RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST, ALPHA_MASK_RST);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        repeat (150) send_beat(random_direct_item());
        drain_results();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // Hold the result side off while beats keep coming, so the input stalls
    task automatic test_receiver_hold();
        set_format(3'd2, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0000_0000);
        hold_requests++;
        repeat (50) send_beat(random_direct_item());
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < PAL_DEPTH; i++) shadow_palette[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_direct_defaults();
        test_mask_corners();
        test_palette_directed();
        test_random_direct();
        test_random_palette();
        test_full_rate();
        test_receiver_hold();
        if (error_count == 0 && expected_conversions.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pfpu_pkg.sv
rtl/pfpu_chan_decode.sv
rtl/pixel_format_pack_unpack_unit.sv
dv/tb_pixel_format_pack_unpack_unit.sv
